[rtl/core/hid_report_queue_latency_macros.svh]
// Assertion macros for the report queue checks.
// Used by the top level only; expects aclk and aresetn in scope.
`ifndef HID_REPORT_QUEUE_LATENCY_MACROS_SVH
`define HID_REPORT_QUEUE_LATENCY_MACROS_SVH

// same-cycle implication, disabled during reset
`define HRQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define HRQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/hrq_pkg.sv]
// Shared types and constants for the report queue.
// No dependencies; imported by hrq_latency and the top level.
package hrq_pkg;

    localparam int OP_W       = 2;
    localparam int REPORT_W   = 64;
    localparam int LENGTH_W   = 16;
    localparam int TIME_W     = 32;
    localparam int LAT_W      = 16;
    localparam int SEQ_W      = 32;
    localparam int S_TDATA_W  = 112;
    localparam int M_TDATA_W  = 152;
    localparam int M_FIELDS_W = REPORT_W + 1 + 3 * LAT_W + SEQ_W;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH      = 2'd0,
        OP_TX_DONE   = 2'd1,
        OP_SET_PRESS = 2'd2
    } op_t;

    typedef struct packed {
        logic [SEQ_W-1:0] seq;
        logic [LAT_W-1:0] usb;
        logic [LAT_W-1:0] pre;
        logic [LAT_W-1:0] raw;
    } lat_t;

endpackage

[rtl/core/hrq_ring.sv]
// Report ring storage: one write port, one registered read port.
// Forwards a same-cycle write to the read address. No package dependency.
module hrq_ring #(
    parameter int DEPTH   = 16,
    parameter int IDX_W   = 4,
    parameter int ENTRY_W = 128
) (
    input  logic               aclk,
    input  logic               wr_en,
    input  logic [IDX_W-1:0]   wr_addr,
    input  logic [ENTRY_W-1:0] wr_data,
    input  logic [IDX_W-1:0]   rd_addr,
    output logic [ENTRY_W-1:0] rd_data
);

    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic [ENTRY_W-1:0] fwd_data_reg;
    logic               fwd_hit_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg  <= mem[rd_addr];
        fwd_data_reg <= wr_data;
        fwd_hit_reg  <= wr_en && (wr_addr == rd_addr);
    end

    assign rd_data = fwd_hit_reg ? fwd_data_reg : rd_data_reg;

endmodule

[rtl/core/hrq_latency.sv]
// Latency registers and measurement counter.
// Depends on hrq_pkg for lat_t and field widths.
module hrq_latency
    import hrq_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              done,
    input  logic [TIME_W-1:0] now_time,
    input  logic [TIME_W-1:0] flight_press,
    input  logic [TIME_W-1:0] flight_queue,
    output lat_t              lat_next
);

    lat_t lat_reg;

    always_comb begin
        lat_next = lat_reg;
        if (done && (flight_queue != '0)) begin
            lat_next.usb = now_time[LAT_W-1:0] - flight_queue[LAT_W-1:0];
            if (flight_press != '0) begin
                lat_next.raw = now_time[LAT_W-1:0] - flight_press[LAT_W-1:0];
                lat_next.pre = flight_queue[LAT_W-1:0] - flight_press[LAT_W-1:0];
            end
            lat_next.seq = lat_reg.seq + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lat_reg <= '0;
        end else begin
            lat_reg <= lat_next;
        end
    end

endmodule

[rtl/core/hid_report_queue_latency.sv]
// Each accepted transaction enters the input stage; its result is held in the result stage.
// One transaction per cycle unless m_tready stalls, set by the single queue-update stage.
// The ring read is prefetched at the next tail index every cycle, so no op waits on it.
// Reset clears ring indices, press time, in-flight stamps, latencies and the counter,
// and sets the endpoint ready; ring storage is not cleared and needs no sweep.
`include "hid_report_queue_latency_macros.svh"

module hid_report_queue_latency
    import hrq_pkg::*;
#(
    parameter int QUEUE_DEPTH  = 16,
    parameter int REPORT_BYTES = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // report_data, report_length, time_value
    input  logic [S_TDATA_W-1:0] s_tdata,
    // op
    input  logic [OP_W-1:0]      s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // send_data, dropped, raw_latency, pre_latency, usb_latency, latency_seq, zero pad
    output logic [M_TDATA_W-1:0] m_tdata,
    // send_valid
    output logic                 m_tuser
);

    localparam int IDX_W   = $clog2(QUEUE_DEPTH);
    localparam int DATA_W  = REPORT_BYTES * 8;
    localparam int LEN_W   = $clog2(REPORT_BYTES + 1);
    localparam int ENTRY_W = DATA_W + 2 * TIME_W;

    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
        logic [IDX_W-1:0] r;
        if (i == IDX_W'(QUEUE_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = i + 1'b1;
        end
        return r;
    endfunction

    // input stage
    logic                in_valid_reg;
    logic [OP_W-1:0]     in_op_reg;
    logic [DATA_W-1:0]   in_data_reg;
    logic [LEN_W-1:0]    in_len_reg;
    logic [TIME_W-1:0]   in_time_reg;
    logic [LEN_W-1:0]    len_sat;

    // queue state
    logic [IDX_W-1:0]    head_reg, head_next;
    logic [IDX_W-1:0]    tail_reg, tail_next;
    logic                ready_reg, ready_next;
    logic [TIME_W-1:0]   press_reg, press_next;
    logic [TIME_W-1:0]   fps_reg, fps_next;
    logic [TIME_W-1:0]   fqs_reg, fqs_next;

    // result stage
    logic                out_valid_reg;
    logic                out_sent_reg;
    logic [REPORT_W-1:0] out_data_reg;
    logic                out_drop_reg;
    lat_t                out_lat_reg;

    logic                adv;
    logic                ring_empty;
    logic                wr_en;
    logic                sent;
    logic                drop;
    logic [DATA_W-1:0]   sent_data;
    logic [DATA_W-1:0]   masked_data;
    logic [ENTRY_W-1:0]  wr_entry;
    logic [ENTRY_W-1:0]  front_entry;
    lat_t                lat_next;

    assign adv        = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready   = !in_valid_reg || adv;
    assign ring_empty = (head_reg == tail_reg);

    assign len_sat = (s_tdata[REPORT_W +: LENGTH_W] > LENGTH_W'(REPORT_BYTES)) ?
                     LEN_W'(REPORT_BYTES) : s_tdata[REPORT_W +: LEN_W];

    always_comb begin
        for (int b = 0; b < REPORT_BYTES; b++) begin
            masked_data[8*b +: 8] = (LEN_W'(b) < in_len_reg) ? in_data_reg[8*b +: 8] : 8'h00;
        end
    end

    assign wr_entry = {in_time_reg, press_reg, masked_data};

    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        ready_next = ready_reg;
        press_next = press_reg;
        fps_next   = fps_reg;
        fqs_next   = fqs_reg;
        wr_en      = 1'b0;
        sent       = 1'b0;
        drop       = 1'b0;
        sent_data  = '0;
        if (adv) begin
            unique case (op_t'(in_op_reg))
                OP_PUSH: begin
                    wr_en     = 1'b1;
                    head_next = ring_next(head_reg);
                    if (head_next == tail_reg) begin
                        drop      = 1'b1;
                        tail_next = ring_next(tail_reg);
                    end
                    if (ready_reg) begin
                        sent       = 1'b1;
                        sent_data  = masked_data;
                        fps_next   = press_reg;
                        fqs_next   = in_time_reg;
                        ready_next = 1'b0;
                        tail_next  = ring_next(tail_next);
                    end
                end
                OP_TX_DONE: begin
                    ready_next = 1'b1;
                    fqs_next   = '0;
                    if (!ring_empty) begin
                        sent       = 1'b1;
                        sent_data  = front_entry[DATA_W-1:0];
                        fps_next   = front_entry[DATA_W +: TIME_W];
                        fqs_next   = front_entry[DATA_W + TIME_W +: TIME_W];
                        ready_next = 1'b0;
                        tail_next  = ring_next(tail_reg);
                    end
                end
                OP_SET_PRESS: begin
                    press_next = in_time_reg;
                end
                default: begin
                end
            endcase
        end
    end

    hrq_ring #(
        .DEPTH   (QUEUE_DEPTH),
        .IDX_W   (IDX_W),
        .ENTRY_W (ENTRY_W)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (head_reg),
        .wr_data (wr_entry),
        .rd_addr (tail_next),
        .rd_data (front_entry)
    );

    hrq_latency u_latency (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .done         (adv && (op_t'(in_op_reg) == OP_TX_DONE)),
        .now_time     (in_time_reg),
        .flight_press (fps_reg),
        .flight_queue (fqs_reg),
        .lat_next     (lat_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            head_reg      <= '0;
            tail_reg      <= '0;
            ready_reg     <= 1'b1;
            press_reg     <= '0;
            fps_reg       <= '0;
            fqs_reg       <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (adv) begin
                in_valid_reg <= 1'b0;
            end
            if (adv) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            ready_reg <= ready_next;
            press_reg <= press_next;
            fps_reg   <= fps_next;
            fqs_reg   <= fqs_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_op_reg   <= s_tuser;
            in_data_reg <= s_tdata[DATA_W-1:0];
            in_len_reg  <= len_sat;
            in_time_reg <= s_tdata[REPORT_W + LENGTH_W +: TIME_W];
        end
        if (adv) begin
            out_sent_reg <= sent;
            out_data_reg <= REPORT_W'(sent_data);
            out_drop_reg <= drop;
            out_lat_reg  <= lat_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_sent_reg;
    assign m_tdata  = {{(M_TDATA_W - M_FIELDS_W){1'b0}},
                       out_lat_reg.seq, out_lat_reg.usb, out_lat_reg.pre, out_lat_reg.raw,
                       out_drop_reg, out_data_reg};

    `HRQ_ASSERT_NOW(a_ready_ring_empty, ready_reg, head_reg == tail_reg,
        "endpoint ready while reports are queued")
    `HRQ_ASSERT_NOW(a_drop_endpoint_busy, adv && drop, !ready_reg && !sent,
        "report dropped while endpoint was ready")
    `HRQ_ASSERT_NEXT(a_done_ready_or_send, adv && (op_t'(in_op_reg) == OP_TX_DONE),
        ready_reg == !m_tuser, "transmit done left endpoint state inconsistent with send")

endmodule
